>>> hdl/ncfs_pkg.sv
`default_nettype none

package ncfs_pkg;

	localparam int SAMPLE_BITS      = 16;
	localparam int PHASE_BITS       = 32;
	localparam int TABLE_INDEX_BITS = 12;
	localparam int QUARTER_BITS     = TABLE_INDEX_BITS - 2;
	localparam int QUARTER_LEN      = 1 << QUARTER_BITS;
	localparam int ENTRY_BITS       = SAMPLE_BITS - 1;
	localparam int PRODUCT_BITS     = 2 * SAMPLE_BITS;
	localparam int SUM_BITS         = PRODUCT_BITS + 1;
	localparam int FRAC_BITS        = SAMPLE_BITS - 1;
	localparam int SCALED_BITS      = SUM_BITS - FRAC_BITS;
	localparam int FULL_SCALE       = (1 << ENTRY_BITS) - 1;
	localparam real HALF_PI         = 1.57079632679489661923;
	localparam real TABLE_STEP_RAD  = HALF_PI / real'(QUARTER_LEN);

	typedef logic [QUARTER_BITS-1:0] qaddr_t;
	typedef logic [ENTRY_BITS-1:0]   qsine_t;
	typedef qsine_t                  qsine_table_t [QUARTER_LEN];

	typedef struct packed {
		logic   en;
		qaddr_t sin_addr;
		qaddr_t cos_addr;
	} rom_req_t;

	typedef struct packed {
		qsine_t sin_data;
		qsine_t cos_data;
	} rom_rsp_t;

	function automatic qsine_table_t build_qsine();
		qsine_table_t t;
		real          a;
		for (int k = 0; k < QUARTER_LEN; k++) begin
			a = TABLE_STEP_RAD * real'(k);
			t[k] = qsine_t'(int'(real'(FULL_SCALE) * $sin(a)));
		end
		return t;
	endfunction

endpackage

`default_nettype wire

>>> hdl/ncfs_sine_rom.sv
`default_nettype none

module ncfs_sine_rom (
	input  wire logic              clk,
	input  wire ncfs_pkg::rom_req_t req,
	output ncfs_pkg::rom_rsp_t      rsp
);
	import ncfs_pkg::*;

	localparam qsine_table_t QSINE = build_qsine();

	always_ff @(posedge clk) begin
		if (req.en) begin
			rsp.sin_data <= QSINE[req.sin_addr];
			rsp.cos_data <= QSINE[req.cos_addr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/nco_complex_frequency_shifter.sv
// channel   signals                                        transfer when
// in        in_valid, in_ready, sample_real/imag/last      in_valid & in_ready
// out       out_valid, out_ready, shifted_real/imag,       out_valid & out_ready
//           result_last, clipped
// cfg       cfg_wr_en, cfg_wr_data (phase_step)            cfg_wr_en
//
// One sample per clock sustained while the output is not stalled; each result passes
// the registered sine ROM read, multiply, and sum with round and saturate in turn.
// The phase accumulator advances by phase_step on every input transfer.
// Reset clears the phase, phase_step and all stage valid flags.
// A stalled output register holds; earlier stages keep filling bubbles,
// and in_ready falls only when every stage holds an item.
`default_nettype none

module nco_complex_frequency_shifter (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [31:0]                         cfg_wr_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [ncfs_pkg::SAMPLE_BITS-1:0] sample_real,
	input  wire logic signed [ncfs_pkg::SAMPLE_BITS-1:0] sample_imag,
	input  wire logic                                sample_last,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [ncfs_pkg::SAMPLE_BITS-1:0]  shifted_real,
	output logic signed [ncfs_pkg::SAMPLE_BITS-1:0]  shifted_imag,
	output logic                                     result_last,
	output logic                                     clipped
);
	import ncfs_pkg::*;

	typedef struct packed {
		qaddr_t addr;
		logic   full;
		logic   neg;
	} lookup_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] value;
		logic                          clip;
	} sat_t;

	localparam logic signed [SCALED_BITS-1:0] SAT_HI =
		SCALED_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [SCALED_BITS-1:0] SAT_LO =
		-SCALED_BITS'(1 << (SAMPLE_BITS - 1));
	localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1 << (FRAC_BITS - 1));

	function automatic lookup_t decode(input logic [TABLE_INDEX_BITS-1:0] idx);
		lookup_t l;
		qaddr_t  r;
		r      = idx[QUARTER_BITS-1:0];
		l.addr = idx[QUARTER_BITS] ? qaddr_t'(-r) : r;
		l.full = idx[QUARTER_BITS] && (r == '0);
		l.neg  = idx[QUARTER_BITS+1];
		return l;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] trig_value(input qsine_t d,
			input logic full, input logic neg);
		logic signed [SAMPLE_BITS-1:0] v;
		v = full ? SAMPLE_BITS'(FULL_SCALE) : {1'b0, d};
		return neg ? -v : v;
	endfunction

	function automatic sat_t round_sat(input logic signed [SUM_BITS-1:0] s);
		logic signed [SUM_BITS-1:0]    rs;
		logic signed [SCALED_BITS-1:0] q;
		sat_t                          o;
		rs = s + ROUND_HALF;
		q  = SCALED_BITS'(rs >>> FRAC_BITS);
		if (q > SAT_HI) begin
			o.value = SAT_HI[SAMPLE_BITS-1:0];
			o.clip  = 1'b1;
		end else if (q < SAT_LO) begin
			o.value = SAT_LO[SAMPLE_BITS-1:0];
			o.clip  = 1'b1;
		end else begin
			o.value = q[SAMPLE_BITS-1:0];
			o.clip  = 1'b0;
		end
		return o;
	endfunction

	logic [PHASE_BITS-1:0] phase_q;
	logic [31:0]           phase_step_q;

	logic                          v_s1, v_s2;
	logic signed [SAMPLE_BITS-1:0] xr_s1, xi_s1;
	logic                          last_s1, last_s2;
	logic                          sin_full_s1, sin_neg_s1, cos_full_s1, cos_neg_s1;
	logic signed [PRODUCT_BITS-1:0] rc_s2, is_s2, rs_s2, ic_s2;

	logic                          in_xfer, ld_s2, ld_out;
	logic [TABLE_INDEX_BITS-1:0]   idx;
	lookup_t                       sin_lk, cos_lk;
	rom_req_t                      rom_req;
	rom_rsp_t                      rom_rsp;
	logic signed [SAMPLE_BITS-1:0] sin_v, cos_v;
	sat_t                          re_sat, im_sat;

	assign ld_out   = v_s2 && (!out_valid || out_ready);
	assign ld_s2    = v_s1 && (!v_s2 || ld_out);
	assign in_ready = !v_s1 || ld_s2;
	assign in_xfer  = in_valid && in_ready;

	assign idx    = phase_q[PHASE_BITS-1 -: TABLE_INDEX_BITS];
	assign sin_lk = decode(idx);
	assign cos_lk = decode(idx + TABLE_INDEX_BITS'(QUARTER_LEN));

	assign rom_req.en       = in_xfer;
	assign rom_req.sin_addr = sin_lk.addr;
	assign rom_req.cos_addr = cos_lk.addr;

	ncfs_sine_rom u_rom (
		.clk (clk),
		.req (rom_req),
		.rsp (rom_rsp)
	);

	assign sin_v = trig_value(rom_rsp.sin_data, sin_full_s1, sin_neg_s1);
	assign cos_v = trig_value(rom_rsp.cos_data, cos_full_s1, cos_neg_s1);

	assign re_sat = round_sat(SUM_BITS'(rc_s2) - SUM_BITS'(is_s2));
	assign im_sat = round_sat(SUM_BITS'(rs_s2) + SUM_BITS'(ic_s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			phase_step_q <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				phase_step_q <= cfg_wr_data;
			end
			if (in_xfer) begin
				phase_q <= phase_q + PHASE_BITS'(phase_step_q);
				v_s1    <= 1'b1;
			end else if (ld_s2) begin
				v_s1 <= 1'b0;
			end
			if (ld_s2) begin
				v_s2 <= 1'b1;
			end else if (ld_out) begin
				v_s2 <= 1'b0;
			end
			if (ld_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			xr_s1       <= sample_real;
			xi_s1       <= sample_imag;
			last_s1     <= sample_last;
			sin_full_s1 <= sin_lk.full;
			sin_neg_s1  <= sin_lk.neg;
			cos_full_s1 <= cos_lk.full;
			cos_neg_s1  <= cos_lk.neg;
		end
		if (ld_s2) begin
			rc_s2   <= PRODUCT_BITS'(xr_s1) * PRODUCT_BITS'(cos_v);
			is_s2   <= PRODUCT_BITS'(xi_s1) * PRODUCT_BITS'(sin_v);
			rs_s2   <= PRODUCT_BITS'(xr_s1) * PRODUCT_BITS'(sin_v);
			ic_s2   <= PRODUCT_BITS'(xi_s1) * PRODUCT_BITS'(cos_v);
			last_s2 <= last_s1;
		end
		if (ld_out) begin
			shifted_real <= re_sat.value;
			shifted_imag <= im_sat.value;
			result_last  <= last_s2;
			clipped      <= re_sat.clip || im_sat.clip;
		end
	end

endmodule

`default_nettype wire

>>> hdl/ncfs_checker.sv
`default_nettype none

module ncfs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] shifted_real,
	input wire logic [15:0] shifted_imag,
	input wire logic        result_last,
	input wire logic        clipped
);

	localparam logic [15:0] POS_RAIL = 16'h7fff;
	localparam logic [15:0] NEG_RAIL = 16'h8000;

	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	a_clip_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clipped) |-> (shifted_real == POS_RAIL || shifted_real == NEG_RAIL ||
			shifted_imag == POS_RAIL || shifted_imag == NEG_RAIL))
		else $error("clipped set with no part at a rail");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(shifted_real) &&
			$stable(shifted_imag) && $stable(result_last) && $stable(clipped)))
		else $error("stalled result changed before transfer");

endmodule

bind nco_complex_frequency_shifter ncfs_checker u_ncfs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.shifted_real (shifted_real),
	.shifted_imag (shifted_imag),
	.result_last  (result_last),
	.clipped      (clipped)
);

`default_nettype wire
